### sv/signed_binary_to_decimal_ascii_top_assert.svh
// Assertion macros for the signed binary to decimal ASCII converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off while reset is asserted.
`define SBDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, held off while reset is asserted.
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/sbda_pkg.sv
// Shared types, constants and helper functions of the decimal ASCII converter.
`default_nettype none

package sbda_pkg;

    // ASCII codes that the converter emits.
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Room for a digit index at any supported width (up to 19 digits).
    localparam int DIGIT_IDX_W = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   load;
        logic                   shift;
        logic                   emit_sign;
        logic                   emit_digit;
        logic                   last;
        logic [DIGIT_IDX_W-1:0] idx;
    } sbda_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                   negative;
        logic                   out_free;
        logic [DIGIT_IDX_W-1:0] lead_idx;
    } sbda_status_t;

    // Number of decimal digits of 2^(width-1), the largest magnitude.
    function automatic int num_digits(input int width);
        logic [63:0] lim;
        logic [63:0] pw;
        int          n;
        lim = 64'd1 << (width - 1);
        pw  = 64'd10;
        n   = 1;
        for (int k = 1; k < 20; k++) begin
            if (pw <= lim) begin
                n = k + 1;
            end
            pw = pw * 64'd10;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### sv/sbda_datapath.sv
// Datapath: magnitude, bit-serial binary to BCD conversion and output register.
`default_nettype none

module sbda_datapath #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10,
    parameter int IDX_W       = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire sbda_pkg::sbda_cmd_t  cmd,
    output sbda_pkg::sbda_status_t    status,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);

    localparam int BCD_W = NDIG * 4;

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic                   neg_reg, neg_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [7:0]             m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [IDX_W-1:0]       lead_idx;
    logic [IDX_W-1:0]       sel_idx;
    logic [3:0]             sel_nib;
    logic                   out_free;

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // Index of the most significant nonzero digit; zero keeps digit 0.
    always_comb begin
        lead_idx = '0;
        for (int i = 1; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0) begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    assign sel_idx  = cmd.idx[IDX_W-1:0];
    assign sel_nib  = bcd_reg[sel_idx*4 +: 4];
    assign out_free = !m_tvalid_reg || m_tready;

    // Magnitude load and one conversion bit per shift command.
    always_comb begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        if (cmd.load) begin
            neg_next = value[VALUE_WIDTH-1];
            mag_next = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
            bcd_next = '0;
        end else if (cmd.shift) begin
            mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
        end
    end

    // Output register: loads a character, clears when the beat is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (cmd.emit_sign) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = sbda_pkg::CHAR_MINUS;
            m_tlast_next  = 1'b0;
        end else if (cmd.emit_digit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = sbda_pkg::CHAR_ZERO + {4'd0, sel_nib};
            m_tlast_next  = cmd.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Control register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign status.negative = neg_reg;
    assign status.out_free = out_free;
    assign status.lead_idx = sbda_pkg::DIGIT_IDX_W'(lead_idx);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

### sv/sbda_ctrl.sv
// Controller: sequences load, conversion, sign and digit beats of one value.
`default_nettype none

module sbda_ctrl #(
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sbda_pkg::sbda_status_t status,
    output sbda_pkg::sbda_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.idx        = sbda_pkg::DIGIT_IDX_W'(idx_reg);
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(VALUE_WIDTH);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                idx_next   = status.lead_idx[IDX_W-1:0];
                state_next = status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    cmd.last       = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

### sv/signed_binary_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII text converter.
//
//  Channel | Dir | tdata (low bit up)        | tlast             | Beats per item
//  s_      | in  | value[VALUE_WIDTH-1:0]    | -                 | 1
//  m_      | out | character[7:0]            | last_char of text | 1 to 11 (32 bits)
//
// An item passes through one accept step, one double-dabble shift per
// magnitude bit and one step to find the leading digit, then one beat per
// character while the m_ side accepts them. One item is in work at a time;
// the next is accepted while the last beat still waits in the output
// register. A stalled m_ side holds the sequencer. Reset is synchronous
// and needs no clearing pass.
`default_nettype none
`include "signed_binary_to_decimal_ascii_top_assert.svh"

module signed_binary_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // value
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [7:0]                                  m_tdata,  // character
    output logic                                        m_tlast   // last_char
);

    localparam int NDIG  = sbda_pkg::num_digits(VALUE_WIDTH);
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    sbda_pkg::sbda_cmd_t    cmd;
    sbda_pkg::sbda_status_t status;

    // Sequencer.
    sbda_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Conversion and output register.
    sbda_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .value    (s_tdata[VALUE_WIDTH-1:0]),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Handshake and character classes used by the checks below.
    logic in_beat;
    logic digit_char;
    logic sign_char;

    assign in_beat    = s_tvalid && s_tready;
    assign digit_char = (m_tdata >= sbda_pkg::CHAR_ZERO) && (m_tdata <= sbda_pkg::CHAR_NINE);
    assign sign_char  = (m_tdata == sbda_pkg::CHAR_MINUS);

    // Only one item is in work: an accept closes the input for the next cycle.
    `SBDA_ASSERT_NEXT(a_one_item, aclk, aresetn, in_beat, !s_tready, "second item accepted")

    // Every beat carries a minus sign or a decimal digit.
    `SBDA_ASSERT_IMPLY(a_char_code, aclk, aresetn, m_tvalid, sign_char || digit_char, "bad character")

    // A minus sign is always followed by digits.
    `SBDA_ASSERT_IMPLY(a_sign_not_last, aclk, aresetn, m_tvalid && sign_char, !m_tlast, "sign is last")

endmodule

`default_nettype wire
